[sv/tsd_pkg.sv]
// ----------------------------------------------------------------------------
// tsd_pkg
// shared codes, widths and word types of the descriptor switch
// ----------------------------------------------------------------------------
package tsd_pkg;

   localparam int REF_W      = 32;
   localparam int LEN_W      = 16;
   localparam int NUM_SINKS  = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic       OP_RX   = 1'b0;
   localparam logic       OP_TICK = 1'b1;

   localparam logic [1:0] SINK_BLE   = 2'd0;
   localparam logic [1:0] SINK_TCP   = 2'd1;
   localparam logic [1:0] SINK_RADIO = 2'd2;

   localparam logic [1:0] KIND_ACCEPT   = 2'd0;
   localparam logic [1:0] KIND_BLOCKED  = 2'd1;
   localparam logic [1:0] KIND_DELIVERY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SINK_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN     = 1'b1;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1024;

   typedef struct packed {
      logic             operation;
      logic [1:0]       source;
      logic [REF_W-1:0] pkt_ref;
      logic [LEN_W-1:0] pkt_len;
      logic             radio_ready;
      logic             ble_ready;
      logic             tcp_ready;
   } req_word_type;

endpackage

[sv/tsd_if.sv]
// ----------------------------------------------------------------------------
// tsd channel interfaces
// request, response and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface tsd_req_if;
   logic                      valid;
   logic                      ready;
   logic                      operation;
   logic [1:0]                rx_source;
   logic [tsd_pkg::REF_W-1:0] pkt_ref;
   logic [tsd_pkg::LEN_W-1:0] pkt_len;
   logic                      radio_ready;
   logic                      ble_ready;
   logic                      tcp_ready;

   modport source (output valid, operation, rx_source, pkt_ref, pkt_len,
                   radio_ready, ble_ready, tcp_ready, input ready);
   modport sink   (input valid, operation, rx_source, pkt_ref, pkt_len,
                   radio_ready, ble_ready, tcp_ready, output ready);
endinterface

interface tsd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                kind;
   logic [1:0]                sink_id;
   logic [tsd_pkg::REF_W-1:0] out_ref;
   logic [tsd_pkg::LEN_W-1:0] out_len;
   logic [1:0]                overwrite_mask;
   logic                      last;

   modport source (output valid, kind, sink_id, out_ref, out_len, overwrite_mask,
                   last, input ready);
   modport sink   (input valid, kind, sink_id, out_ref, out_len, overwrite_mask,
                   last, output ready);
endinterface

interface tsd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [tsd_pkg::CSR_IDX_W-1:0]  index;
   logic [tsd_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/three_sink_descriptor_switch_core.sv]
// ----------------------------------------------------------------------------
// three_sink_descriptor_switch_core
// descriptor switch with two overwriting rings and one no-drop ring
// ----------------------------------------------------------------------------
// pipeline: a request word is held in the input register, then its result words
//    in the result stage; the input register waits until the last pending result word is taken
// throughput: one request word per cycle while the result stage can take it; a tick
//    with n deliveries gives n response words on the single response channel
// reset: pointers, counts, hold flag and pending results clear at once;
//    enable mask 0, max_len 1024; ring storage is not cleared and needs no pass
// ----------------------------------------------------------------------------
module three_sink_descriptor_switch_core #(
   parameter int RING_DEPTH = 32,
   parameter int REF_WIDTH  = 32
) (
   input  logic      clock,
   input  logic      reset,
   tsd_req_if.sink   req_bus,
   tsd_rsp_if.source rsp_bus,
   tsd_csr_if.sink   csr_bus
);

   localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W   = $clog2(RING_DEPTH + 1);
   localparam int ENTRY_W = REF_WIDTH + tsd_pkg::LEN_W;
   localparam int NS      = tsd_pkg::NUM_SINKS;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   // configuration
   logic [2:0]                enable_ff;
   logic [tsd_pkg::LEN_W-1:0] max_len_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= '0;
         max_len_ff <= tsd_pkg::MAX_LEN_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            tsd_pkg::CSR_SINK_ENABLE: enable_ff  <= csr_bus.data[2:0];
            tsd_pkg::CSR_MAX_LEN:     max_len_ff <= csr_bus.data;
            default:                  enable_ff  <= enable_ff;
         endcase
      end
   end

   // input register
   logic                  in_valid_ff;
   tsd_pkg::req_word_type in_word_ff;
   logic                  advance;
   logic                  stage2_free;

   assign advance       = in_valid_ff && stage2_free;
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_word_ff.operation   <= req_bus.operation;
         in_word_ff.source      <= req_bus.rx_source;
         in_word_ff.pkt_ref     <= req_bus.pkt_ref;
         in_word_ff.pkt_len     <= req_bus.pkt_len;
         in_word_ff.radio_ready <= req_bus.radio_ready;
         in_word_ff.ble_ready   <= req_bus.ble_ready;
         in_word_ff.tcp_ready   <= req_bus.tcp_ready;
      end
   end

   // ring control state
   logic [PTR_W-1:0]   head_ff  [NS];
   logic [PTR_W-1:0]   head_in  [NS];
   logic [PTR_W-1:0]   tail_ff  [NS];
   logic [PTR_W-1:0]   tail_in  [NS];
   logic [CNT_W-1:0]   count_ff [NS];
   logic [CNT_W-1:0]   count_in [NS];
   logic               holding_ff;
   logic               holding_in;
   logic [NS-1:0]      wr_en;
   logic [NS-1:0]      rd_en;
   logic [NS-1:0]      full;
   logic [NS-1:0]      dlv;
   logic [1:0]         ovw;
   logic               blocked;
   logic               len_bad;
   logic               take;
   logic [NS-1:0]      sink_ready;
   logic [ENTRY_W-1:0] wr_entry;
   logic [ENTRY_W-1:0] rd_ff    [NS];

   assign wr_entry   = {REF_WIDTH'(in_word_ff.pkt_ref), in_word_ff.pkt_len};
   assign len_bad    = (in_word_ff.pkt_len == '0) || (in_word_ff.pkt_len > max_len_ff);
   assign sink_ready = {in_word_ff.radio_ready, in_word_ff.tcp_ready,
                        in_word_ff.ble_ready};

   always_comb begin
      for (int s = 0; s < NS; s++) begin
         head_in[s]  = head_ff[s];
         tail_in[s]  = tail_ff[s];
         count_in[s] = count_ff[s];
         full[s]     = (count_ff[s] == FULL_CNT);
      end
      holding_in = holding_ff;
      wr_en      = '0;
      rd_en      = '0;
      dlv        = '0;
      blocked    = 1'b0;
      take       = 1'b0;
      if (advance) begin
         if (in_word_ff.operation == tsd_pkg::OP_RX) begin
            if (!len_bad) begin
               if (enable_ff[2] && (in_word_ff.source != tsd_pkg::SINK_RADIO) &&
                   full[2]) begin
                  blocked = 1'b1;
               end else begin
                  for (int s = 0; s < NS; s++) begin
                     if (enable_ff[s] && (in_word_ff.source != 2'(s))) begin
                        wr_en[s]   = 1'b1;
                        head_in[s] = next_ptr(head_ff[s]);
                        if (full[s]) begin
                           tail_in[s] = next_ptr(tail_ff[s]);
                        end else begin
                           count_in[s] = count_ff[s] + 1'b1;
                        end
                     end
                  end
               end
            end
         end else begin
            if (enable_ff[2]) begin
               take = !holding_ff && (count_ff[2] != '0);
               if (take) begin
                  rd_en[2]    = 1'b1;
                  tail_in[2]  = next_ptr(tail_ff[2]);
                  count_in[2] = count_ff[2] - 1'b1;
               end
               if ((holding_ff || take) && sink_ready[2]) begin
                  dlv[2]     = 1'b1;
                  holding_in = 1'b0;
               end else begin
                  holding_in = holding_ff || take;
               end
            end
            for (int s = 0; s < 2; s++) begin
               if (enable_ff[s] && sink_ready[s] && (count_ff[s] != '0)) begin
                  rd_en[s]    = 1'b1;
                  dlv[s]      = 1'b1;
                  tail_in[s]  = next_ptr(tail_ff[s]);
                  count_in[s] = count_ff[s] - 1'b1;
               end
            end
         end
      end
      ovw = {wr_en[1] & full[1], wr_en[0] & full[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            head_ff[s]  <= '0;
            tail_ff[s]  <= '0;
            count_ff[s] <= '0;
         end
         holding_ff <= 1'b0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            head_ff[s]  <= head_in[s];
            tail_ff[s]  <= tail_in[s];
            count_ff[s] <= count_in[s];
         end
         holding_ff <= holding_in;
      end
   end

   // ring storage; the radio read register doubles as the held descriptor
   for (genvar g = 0; g < NS; g++) begin : g_ring
      logic [ENTRY_W-1:0] mem [RING_DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en[g]) begin
            mem[head_ff[g]] <= wr_entry;
         end
         if (rd_en[g]) begin
            rd_ff[g] <= mem[tail_ff[g]];
         end
      end
   end

   // result stage
   logic               res_rx_ff;
   logic [1:0]         res_kind_ff;
   logic [1:0]         res_ovw_ff;
   logic [NS-1:0]      res_dlv_ff;
   logic               busy;
   logic               rsp_fire;
   logic               res_last;
   logic [1:0]         sel;
   logic [NS-1:0]      sel_bit;
   logic [ENTRY_W-1:0] sel_entry;

   assign busy        = res_rx_ff || (res_dlv_ff != '0);
   assign rsp_fire    = rsp_bus.valid && rsp_bus.ready;
   assign res_last    = res_rx_ff || ((res_dlv_ff & (res_dlv_ff - 1'b1)) == '0);
   assign stage2_free = !busy || (rsp_fire && res_last);

   always_comb begin
      priority if (res_dlv_ff[2]) begin
         sel     = tsd_pkg::SINK_RADIO;
         sel_bit = 3'b100;
      end else if (res_dlv_ff[0]) begin
         sel     = tsd_pkg::SINK_BLE;
         sel_bit = 3'b001;
      end else begin
         sel     = tsd_pkg::SINK_TCP;
         sel_bit = 3'b010;
      end
   end

   always_comb begin
      unique case (sel)
         tsd_pkg::SINK_BLE: sel_entry = rd_ff[0];
         tsd_pkg::SINK_TCP: sel_entry = rd_ff[1];
         default:           sel_entry = rd_ff[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_rx_ff  <= 1'b0;
         res_dlv_ff <= '0;
      end else if (advance) begin
         res_rx_ff  <= (in_word_ff.operation == tsd_pkg::OP_RX);
         res_dlv_ff <= dlv;
      end else if (rsp_fire) begin
         if (res_rx_ff) begin
            res_rx_ff <= 1'b0;
         end else begin
            res_dlv_ff <= res_dlv_ff & ~sel_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_kind_ff <= blocked ? tsd_pkg::KIND_BLOCKED : tsd_pkg::KIND_ACCEPT;
         res_ovw_ff  <= ovw;
      end
   end

   assign rsp_bus.valid          = busy;
   assign rsp_bus.kind           = res_rx_ff ? res_kind_ff : tsd_pkg::KIND_DELIVERY;
   assign rsp_bus.sink_id        = res_rx_ff ? tsd_pkg::SINK_BLE : sel;
   assign rsp_bus.out_ref        = res_rx_ff ? '0 :
                                   tsd_pkg::REF_W'(sel_entry[ENTRY_W-1:tsd_pkg::LEN_W]);
   assign rsp_bus.out_len        = res_rx_ff ? '0 : sel_entry[tsd_pkg::LEN_W-1:0];
   assign rsp_bus.overwrite_mask = res_rx_ff ? res_ovw_ff : 2'b00;
   assign rsp_bus.last           = res_last;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff[0] <= FULL_CNT) && (count_ff[1] <= FULL_CNT) && (count_ff[2] <= FULL_CNT))
      else $error("ring count above depth");

   a_radio_no_drop: assert property (@(posedge clock) disable iff (reset)
      wr_en[2] |-> !full[2])
      else $error("radio ring written while full");

   a_multi_word_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !res_last) |=> busy)
      else $error("pending deliveries lost");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_word_ff)))
      else $error("stalled request word changed");

   a_hold_source: assert property (@(posedge clock) disable iff (reset)
      $rose(holding_ff) |-> ($past(count_ff[2]) != '0))
      else $error("hold taken from empty radio ring");

endmodule
